FILE: hw/rtl/php_pkg.sv
// php_pkg: shared types and constants of the pc histogram profiler.
// No dependencies; imported by every rtl file of the block.
package php_pkg;

  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_DUMP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_WORDS = 2'd1;

  localparam int unsigned WORD_BYTES = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] pc;
    logic [31:0] cyc_begin;
    logic [31:0] cyc_finish;
    logic [31:0] threshold;
  } in_word_t;

  typedef struct packed {
    logic [31:0] entry_pc;
    logic [31:0] hit_count;
    logic [31:0] mean_cycles;
    logic [31:0] total_instructions;
    logic        entry_valid;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_SCAN,
    S_DIV,
    S_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic rec_rd;
    logic rec_wr;
    logic clr;
    logic scan_init;
    logic scan_run;
    logic div_start;
    logic emit;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic div_done;
  } status_t;

endpackage

FILE: hw/rtl/php_div.sv
// php_div: restoring 32-bit unsigned divider, one quotient bit per cycle.
// Imports php_pkg; no other dependencies.
module php_div import php_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] dq_r, rem_r, den_r;
  logic [4:0]  cnt_r;
  logic        act_r, done_r;
  logic [32:0] trial, diff;

  assign trial = {rem_r, dq_r[31]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (act_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        dq_r  <= {dq_r[30:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        dq_r  <= {dq_r[30:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

FILE: hw/rtl/php_dp.sv
// php_dp: datapath - config registers, count and sum tables, dump scan, result register.
// Depends on php_pkg and php_div.
module php_dp import php_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  in_word_t    in_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_strobe,
  output out_word_t   out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(DEPTH);

  logic [31:0] base_r;
  logic [6:0]  words7_r;
  logic [AW:0] words;

  logic [31:0] hit_mem [DEPTH];
  logic [31:0] sum_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  logic [31:0] cnt_q_r, sum_q_r;
  logic        vq_r;
  logic [31:0] eff_cnt, eff_sum;

  logic [AW-1:0] slot_r, rd_addr;
  logic          inr_r;
  logic [31:0]   delta_r, thr_r, total_r;
  logic [31:0]   diff_in;
  logic          inr_in;

  logic [AW:0]   sidx_r;
  logic [AW-1:0] pidx_r;
  logic          pv_r;

  logic [AW-1:0] best_idx_r;
  logic [31:0]   best_cnt_r, best_sum_r;
  logic          best_vld_r;
  logic [31+AW:0] key, best_key, prev_key_r;
  logic          have_prev_r;
  logic          qual, better;

  logic          have_pend_r;
  logic [31:0]   pend_pc_r, pend_cnt_r, pend_avg_r;

  logic          div_done;
  logic [31:0]   quo;
  logic          out_strobe_r;
  out_word_t     out_r;

  assign words = (words7_r > DEPTH7) ? (AW+1)'(DEPTH) : words7_r[AW:0];

  // slot of the incoming pc; wraps below the base and lands out of range
  assign diff_in = in_word.pc - base_r;
  assign inr_in  = diff_in[31:2] < 30'(words);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      words7_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  base_r   <= cfg_wdata;
        CFG_WORDS: words7_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign rd_addr = cmd.rec_rd ? diff_in[AW+1:2] : sidx_r[AW-1:0];

  always_ff @(posedge clk) begin
    cnt_q_r <= hit_mem[rd_addr];
    sum_q_r <= sum_mem[rd_addr];
    vq_r    <= vld_r[rd_addr];
    if (cmd.rec_wr && inr_r) begin
      hit_mem[slot_r] <= eff_cnt + 32'd1;
      sum_mem[slot_r] <= eff_sum + delta_r;
    end
  end

  assign eff_cnt = vq_r ? cnt_q_r : '0;
  assign eff_sum = vq_r ? sum_q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      total_r <= '0;
    end else begin
      if (cmd.clr) vld_r <= '0;
      else if (cmd.rec_wr && inr_r) vld_r[slot_r] <= 1'b1;
      if (cmd.rec_rd) total_r <= total_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r  <= diff_in[AW+1:2];
      inr_r   <= inr_in;
      delta_r <= in_word.cyc_finish - in_word.cyc_begin;
      thr_r   <= in_word.threshold;
    end
  end

  // scan: order key is count high, inverted index low, so larger key reports first
  assign key      = {eff_cnt, ~pidx_r};
  assign best_key = {best_cnt_r, ~best_idx_r};
  assign qual     = (eff_cnt >= thr_r) && (!have_prev_r || key < prev_key_r);
  assign better   = !best_vld_r || key > best_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r      <= '0;
      pv_r        <= 1'b0;
      best_vld_r  <= 1'b0;
      have_prev_r <= 1'b0;
      have_pend_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        have_prev_r <= 1'b0;
        have_pend_r <= 1'b0;
      end
      if (cmd.scan_init) begin
        sidx_r     <= '0;
        pv_r       <= 1'b0;
        best_vld_r <= 1'b0;
      end else if (cmd.scan_run) begin
        pv_r <= sidx_r < words;
        if (sidx_r < words) sidx_r <= sidx_r + 1'b1;
        if (pv_r && qual && better) best_vld_r <= 1'b1;
      end
      if (cmd.emit) begin
        have_pend_r <= 1'b1;
        have_prev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run) begin
      pidx_r <= sidx_r[AW-1:0];
      if (pv_r && qual && better) begin
        best_idx_r <= pidx_r;
        best_cnt_r <= eff_cnt;
        best_sum_r <= eff_sum;
      end
    end
    if (cmd.emit) begin
      prev_key_r <= best_key;
      pend_pc_r  <= base_r + {{(30-AW){1'b0}}, best_idx_r, 2'b00};
      pend_cnt_r <= best_cnt_r;
      pend_avg_r <= (best_cnt_r == '0) ? '0 : quo;
    end
  end

  php_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (best_sum_r),
    .divisor  (best_cnt_r),
    .done     (div_done),
    .quotient (quo)
  );

  // results leave one behind the scan so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.emit && have_pend_r) || cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.fin) begin
      out_r.entry_pc           <= have_pend_r ? pend_pc_r : '0;
      out_r.hit_count          <= have_pend_r ? pend_cnt_r : '0;
      out_r.mean_cycles        <= have_pend_r ? pend_avg_r : '0;
      out_r.total_instructions <= total_r;
      out_r.entry_valid        <= have_pend_r;
      out_r.last               <= cmd.fin;
    end
  end

  assign status.scan_done = (sidx_r >= words) && !pv_r;
  assign status.found     = best_vld_r;
  assign status.div_done  = div_done;
  assign out_strobe       = out_strobe_r;
  assign out_word         = out_r;

`ifndef SYNTHESIS
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> (vld_r == '0)) else $error("clear left valid bits set");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_rd |=> (total_r == $past(total_r) + 32'd1)) else $error("total not counted");
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_r.last) |-> out_r.entry_valid) else $error("bad mid-dump word");
`endif

endmodule

FILE: hw/rtl/php_ctrl.sv
// php_ctrl: sequencer for record, clear and dump.
// Depends on php_pkg.
module php_ctrl import php_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] action,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = start && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && action == ACT_RECORD) state_nxt = S_REC;
        else if (acc && action == ACT_DUMP) state_nxt = S_SCAN;
      end
      S_REC:  state_nxt = S_IDLE;
      S_SCAN: begin
        if (status.scan_done) state_nxt = status.found ? S_DIV : S_FIN;
      end
      S_DIV:  if (status.div_done) state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_SCAN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load      = acc;
        cmd.rec_rd    = acc && action == ACT_RECORD;
        cmd.clr       = acc && action == ACT_CLEAR;
        cmd.scan_init = acc && action == ACT_DUMP;
      end
      S_REC:  cmd.rec_wr = 1'b1;
      S_SCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.div_start = status.scan_done && status.found;
      end
      S_DIV:  ;
      S_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.scan_init = 1'b1;
      end
      S_FIN:  cmd.fin = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: hw/rtl/pc_histogram_profiler.sv
// pc_histogram_profiler: top level, controller plus datapath.
// Depends on php_pkg, php_ctrl, php_dp (which holds php_div).
//
// Per-word histogram of executed pcs. An input word is taken when start is high and
// busy low. For a record word the count and sum tables are read on the accept
// edge and written back in the next cycle. A clear word drops the valid bit that
// the tables carry per entry. A dump walks the table once per reported entry and
// once more to find none, all through the single table read port; each found entry
// then passes through the serial divider for its average and an emit state, and
// the final word is posted after the last walk.
// Results come out on out_word, one cycle each,
// marked by out_strobe; the receiver cannot stall, so take every strobed word.
// The final word of a dump has last set; an empty dump gives one word with
// entry_valid clear. Config writes are for idle time only.
module pc_histogram_profiler import php_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_strobe,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  php_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_word.action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  php_dp #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

FILE: sim/php_checker.sv
// php_checker: watches the pc histogram profiler channels, predicts dump words
// and compares them field by field. Depends on php_pkg only.
`timescale 1ns / 1ps
module php_checker import php_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_strobe,
  input  out_word_t out_word,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  output int        fails,
  output int        pending,
  output int        seen
);

  logic [31:0] base_addr;
  logic [6:0]  region_words;
  logic [31:0] hits [64];
  logic [31:0] sums [64];
  logic [31:0] total_recs;
  out_word_t   dump_words [$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("checker: %s mismatch, got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic apply_word(in_word_t w);
    int unsigned rs;
    int unsigned n;
    int unsigned pos;
    logic [31:0] slot;
    logic [5:0]  ord [64];
    out_word_t   e;
    rs = (region_words > 64) ? 64 : region_words;
    case (w.action)
      ACT_RECORD: begin
        slot = (w.pc - base_addr) >> 2;
        total_recs++;
        if (slot < rs) begin
          hits[slot] += 1;
          sums[slot] += w.cyc_finish - w.cyc_begin;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < 64; i++) begin
          hits[i] = '0;
          sums[i] = '0;
        end
      end
      ACT_DUMP: begin
        n = 0;
        // stable sort by count, high first; ties stay in address order
        for (int i = 0; i < rs; i++) begin
          if (hits[i] >= w.threshold) begin
            pos = n;
            while (pos > 0 && hits[ord[pos-1]] < hits[i]) begin
              ord[pos] = ord[pos-1];
              pos--;
            end
            ord[pos] = i[5:0];
            n++;
          end
        end
        if (n == 0) begin
          e = '0;
          e.total_instructions = total_recs;
          e.last = 1'b1;
          dump_words.push_back(e);
        end
        for (int i = 0; i < n; i++) begin
          e.entry_pc           = base_addr + {24'd0, ord[i], 2'b00};
          e.hit_count          = hits[ord[i]];
          e.mean_cycles        = (e.hit_count == 0) ? '0 : sums[ord[i]] / e.hit_count;
          e.total_instructions = total_recs;
          e.entry_valid        = 1'b1;
          e.last               = (i == n - 1);
          dump_words.push_back(e);
        end
      end
      default: ;  // unused action: no effect
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      base_addr = '0;
      region_words = 7'd64;
      total_recs = '0;
      for (int i = 0; i < 64; i++) begin
        hits[i] = '0;
        sums[i] = '0;
      end
      dump_words.delete();
      fails = 0;
      seen = 0;
    end else begin
      if (out_strobe) begin
        seen++;
        if (dump_words.size() == 0) begin
          report("unexpected word", out_word.entry_pc, '0);
        end else begin
          e = dump_words.pop_front();
          if (out_word.entry_pc !== e.entry_pc) report("entry_pc", out_word.entry_pc, e.entry_pc);
          if (out_word.hit_count !== e.hit_count)
            report("hit_count", out_word.hit_count, e.hit_count);
          if (out_word.mean_cycles !== e.mean_cycles)
            report("mean_cycles", out_word.mean_cycles, e.mean_cycles);
          if (out_word.total_instructions !== e.total_instructions)
            report("total_instructions", out_word.total_instructions, e.total_instructions);
          if (out_word.entry_valid !== e.entry_valid)
            report("entry_valid", out_word.entry_valid, e.entry_valid);
          if (out_word.last !== e.last) report("last", out_word.last, e.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  base_addr = cfg_wdata;
          CFG_WORDS: region_words = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (start && !busy) apply_word(in_word);
    end
    pending = dump_words.size();
  end

endmodule

FILE: sim/pc_histogram_profiler_tb.sv
// pc_histogram_profiler_tb: stimulus and verdict for the pc histogram profiler.
// Depends on php_pkg, the block's rtl and php_checker.
`timescale 1ns / 1ps
module pc_histogram_profiler_tb;
  import php_pkg::*;

  localparam logic [1:0] CFG_UNMAPPED = 2'd3;  // index with no register behind it
  localparam logic [1:0] ACT_UNUSED   = 2'd3;  // action code with no effect
  localparam int STALL_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_word_t   in_word;
  logic       out_strobe;
  out_word_t  out_word;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;
  int         fails, pending, seen;

  // testbench's own view of the region, used only to aim record pcs
  logic [31:0] cur_base;
  int unsigned cur_words;
  int          sent, dumps, quiet;

  pc_histogram_profiler i_dut (.*);

  php_checker i_chk (
    .clk, .rst_n, .start, .busy, .in_word, .out_strobe, .out_word,
    .cfg_we, .cfg_index, .cfg_wdata, .fails, .pending, .seen
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: any accepted word or result restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Hold start until the word is taken; gaps about 12 in 100 outside the burst.
  task automatic send(in_word_t w, bit may_gap);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sent++;
    if (w.action == ACT_DUMP) dumps++;
    if (may_gap && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait until every predicted word is out and the block has settled.
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_word_t rec(logic [31:0] pc, logic [31:0] t0, logic [31:0] t1);
    in_word_t w;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.action = ACT_RECORD;
    w.pc = pc;
    w.cyc_begin = t0;
    w.cyc_finish = t1;
    return w;
  endfunction

  function automatic in_word_t op(logic [1:0] act, logic [31:0] thr);
    in_word_t w;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.action = act;
    w.threshold = thr;
    return w;
  endfunction

  // mostly well-formed pcs inside (or just past) the region, some wild ones
  function automatic in_word_t rand_rec();
    logic [31:0] pc, t0;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)      pc = $urandom;
    else if (r < 15) pc = cur_base - 32'd4;
    else             pc = cur_base + 4 * $urandom_range(0, cur_words + 1)
                          + ((r < 25) ? $urandom_range(0, 3) : 0);
    t0 = $urandom;
    return rec(pc, t0, ($urandom_range(0, 9) == 0) ? $urandom : t0 + $urandom_range(0, 60));
  endfunction

  function automatic logic [31:0] rand_thr();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  initial begin
    logic [31:0] bases [6];
    int unsigned sizes [6];
    int          r;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE;
    cfg_wdata = '0;
    quiet = 0;
    sent = 0;
    dumps = 0;
    cur_base = '0;
    cur_words = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config (base 0, 64 words)
    send(op(ACT_DUMP, 32'd1), 1'b0);                          // empty dump
    send(op(ACT_DUMP, 32'd0), 1'b0);                          // all zero counts
    send(rec(32'h0, 32'h0, 32'hFFFF_FFFF), 1'b0);             // max delta
    send(rec(32'h0, 32'h0, 32'hFFFF_FFFF), 1'b0);             // cycle sum wraps
    send(rec(32'hFC, 32'hFFFF_FFFF, 32'h0), 1'b0);            // last slot, delta wraps
    send(rec(32'h100, 32'h5, 32'h9), 1'b0);                   // just out of range
    send(rec(32'hFFFF_FFFF, 32'h0, 32'h3), 1'b0);             // far out of range
    send(rec(32'h7, 32'h10, 32'h13), 1'b0);                   // unaligned pc
    send(rec(32'h4, 32'h10, 32'h18), 1'b0);
    send(op(ACT_UNUSED, 32'hFFFF_FFFF), 1'b0);                // unused action
    send(op(ACT_DUMP, 32'd2), 1'b0);
    send(op(ACT_DUMP, 32'hFFFF_FFFF), 1'b0);                  // nothing qualifies
    send(op(ACT_DUMP, 32'd0), 1'b0);
    send(op(ACT_CLEAR, 32'd0), 1'b0);
    send(op(ACT_DUMP, 32'd1), 1'b0);                          // empty after clear
    drain();
    cfg_write(CFG_UNMAPPED, 32'hFFFF_FFFF);                   // must do nothing
    cfg_write(CFG_BASE, 32'hFFFF_FFF8);                       // region wraps past zero
    cfg_write(CFG_WORDS, {25'h1FF_FFFF, 7'd4});
    cur_base = 32'hFFFF_FFF8;
    cur_words = 4;
    send(rec(32'hFFFF_FFF8, 32'd0, 32'd7), 1'b0);
    send(rec(32'h0000_0004, 32'd0, 32'd9), 1'b0);             // slot 3 across the wrap
    send(rec(32'hFFFF_FFF4, 32'd0, 32'd1), 1'b0);             // below base
    send(op(ACT_DUMP, 32'd0), 1'b0);

    // random phases over several region settings, extremes included
    bases = '{32'h0, 32'hFFFF_FFF0, $urandom, 32'h0000_1000, $urandom, $urandom & ~32'h3};
    sizes = '{64, 8, 0, 127, 1, 20};
    for (int p = 0; p < 6; p++) begin
      drain();
      cfg_write(CFG_BASE, bases[p]);
      cfg_write(CFG_WORDS, {25'($urandom_range(0, 32'h1FF_FFFF)), sizes[p][6:0]});
      cur_base = bases[p];
      cur_words = (sizes[p] > 64) ? 64 : sizes[p];
      for (int k = 0; k < 40; k++) begin
        // one quiet pause per phase: let every dump word drain first
        if (k == 20) drain();
        r = $urandom_range(0, 99);
        if (r < 84)      send(rand_rec(), !(p == 2 || p == 3));
        else if (r < 90) send(op(ACT_DUMP, rand_thr()), !(p == 2 || p == 3));
        else if (r < 96) send(op(ACT_CLEAR, $urandom), !(p == 2 || p == 3));
        else             send(op(ACT_UNUSED, $urandom), !(p == 2 || p == 3));
      end
      send(op(ACT_DUMP, rand_thr()), 1'b1);
    end

    drain();
    repeat (40) @(posedge clk);
    $display("summary: %0d words sent (%0d dumps), %0d result words checked", sent, dumps,
             seen);
    $display("summary: regions of 0 to 127 words, wrapping bases, empty and full dumps");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
